// ----- rtl/msb_first_bit_packer_core_assert.svh -----
// Assertion macros for the MSB-first bit packer.
// Used by the top level; no other dependencies.
`ifndef MSB_FIRST_BIT_PACKER_CORE_ASSERT_SVH
`define MSB_FIRST_BIT_PACKER_CORE_ASSERT_SVH

// Check a property on the rising clock edge, ignored while reset is high.
`define MBP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define MBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/mbp_pkg.sv -----
// Shared types, constants and helper functions of the MSB-first bit packer.
// No dependencies.
`default_nettype none

package mbp_pkg;

   localparam int ACC_BITS  = 32;
   localparam int BYTE_BITS = 8;
   localparam int LEN_W     = 6;
   localparam int COUNT_W   = 3;

   localparam logic [LEN_W-1:0] FREE_FULL = LEN_W'(ACC_BITS);

   typedef enum logic [0:0] {
      OP_PUT   = 1'b0,
      OP_FLUSH = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [LEN_W-1:0]    bit_length;
      logic [ACC_BITS-1:0] code_value;
   } item_type;

   typedef struct packed {
      logic [ACC_BITS-1:0] out_word;
      logic [COUNT_W-1:0]  byte_count;
      logic                from_flush;
   } result_type;

   typedef struct packed {
      logic                emit;
      result_type          result;
      logic [ACC_BITS-1:0] acc_next;
      logic [LEN_W-1:0]    free_next;
   } step_type;

   // Ones in the low len bits; a length of 32 or more gives all ones.
   function automatic logic [ACC_BITS-1:0] low_mask(input logic [LEN_W-1:0] len);
      low_mask = ~({ACC_BITS{1'b1}} << len);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/mbp_in_stage.sv -----
// Input register of the MSB-first bit packer: holds one request transfer.
// Depends on mbp_pkg.
`default_nettype none

module mbp_in_stage (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_opcode,
   input  wire logic [mbp_pkg::LEN_W-1:0]     req_bit_length,
   input  wire logic [mbp_pkg::ACC_BITS-1:0]  req_code_value,
   input  wire logic                          advance,
   output logic                               item_valid,
   output mbp_pkg::item_type                  item
);

   logic              valid_ff, valid_in;
   mbp_pkg::item_type item_ff, item_in;

   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
      if (req_valid && req_ready) begin
         item_in.opcode     = mbp_pkg::opcode_type'(req_opcode);
         item_in.bit_length = req_bit_length;
         item_in.code_value = req_code_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ----- rtl/mbp_pack_step.sv -----
// Packing logic of the MSB-first bit packer: next accumulator state and the
// optional result for one item. Depends on mbp_pkg.
`default_nettype none

module mbp_pack_step (
   input  wire mbp_pkg::item_type            item,
   input  wire logic [mbp_pkg::ACC_BITS-1:0] acc,
   input  wire logic [mbp_pkg::LEN_W-1:0]    free_bits,
   output mbp_pkg::step_type                 step
);

   logic [mbp_pkg::LEN_W-1:0]    len_c;
   logic [mbp_pkg::ACC_BITS-1:0] val_m;
   logic [mbp_pkg::LEN_W-1:0]    pending;
   logic [mbp_pkg::LEN_W-1:0]    round_up;
   logic [mbp_pkg::COUNT_W-1:0]  nbytes;
   logic [mbp_pkg::LEN_W-1:0]    pad_bits;
   logic [mbp_pkg::LEN_W-1:0]    rest;
   logic [mbp_pkg::LEN_W:0]      free_wrap;

   always_comb begin
      // clamp oversized lengths to a full word
      if (item.bit_length > mbp_pkg::FREE_FULL) begin
         len_c = mbp_pkg::FREE_FULL;
      end else begin
         len_c = item.bit_length;
      end
      val_m     = item.code_value & mbp_pkg::low_mask(len_c);
      pending   = mbp_pkg::FREE_FULL - free_bits;
      round_up  = pending + mbp_pkg::LEN_W'(mbp_pkg::BYTE_BITS - 1);
      nbytes    = round_up[mbp_pkg::LEN_W-1:3];
      pad_bits  = mbp_pkg::FREE_FULL - {nbytes, 3'b000};
      rest      = len_c - free_bits;
      free_wrap = {1'b0, free_bits} + (mbp_pkg::LEN_W+1)'(mbp_pkg::ACC_BITS)
                  - {1'b0, len_c};

      step.emit              = 1'b0;
      step.result.out_word   = '0;
      step.result.byte_count = '0;
      step.result.from_flush = 1'b0;
      step.acc_next          = acc;
      step.free_next         = free_bits;

      unique case (item.opcode)
         mbp_pkg::OP_FLUSH: begin
            step.acc_next  = '0;
            step.free_next = mbp_pkg::FREE_FULL;
            if (free_bits != mbp_pkg::FREE_FULL) begin
               // left-align pending bits, drop anything below the last byte
               step.emit              = 1'b1;
               step.result.out_word   = (acc << free_bits) & ~mbp_pkg::low_mask(pad_bits);
               step.result.byte_count = nbytes;
               step.result.from_flush = 1'b1;
            end
         end
         mbp_pkg::OP_PUT: begin
            if (len_c < free_bits) begin
               step.acc_next  = (acc << len_c) | val_m;
               step.free_next = free_bits - len_c;
            end else begin
               // word completes: top part of the code closes it, rest stays
               step.emit              = 1'b1;
               step.result.out_word   = (acc << free_bits) | (val_m >> rest);
               step.result.byte_count = mbp_pkg::COUNT_W'(mbp_pkg::ACC_BITS
                                                          / mbp_pkg::BYTE_BITS);
               step.result.from_flush = 1'b0;
               step.acc_next          = val_m & mbp_pkg::low_mask(rest);
               step.free_next         = free_wrap[mbp_pkg::LEN_W-1:0];
            end
         end
         default: begin
            step.emit = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/msb_first_bit_packer_core.sv -----
// Top level of the MSB-first bit packer: input register, packing logic,
// accumulator and result register. Depends on mbp_pkg, mbp_in_stage, mbp_pack_step.
`default_nettype none

// Packs put codes of 0 to 32 bits MSB-first into a 32-bit accumulator and
// hands out one big-endian word each time 32 bits are complete; a flush
// returns the pending bits as 1 to 4 zero-padded bytes and empties the
// accumulator. Unless held back as described below, the block takes one item
// per clock cycle: an item is registered on transfer in the input register,
// then passes the barrel-shift packing logic and updates the accumulator, the
// only register in the accumulator feedback loop. An item that yields a word
// shows it on the rsp_ port from the edge at which it leaves the input
// register; items that yield nothing never wait on the result register. Only
// a result register held by a stalled rsp_ready holds back a word-producing item.

module msb_first_bit_packer_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_opcode,
   input  wire logic [mbp_pkg::LEN_W-1:0]     req_bit_length,
   input  wire logic [mbp_pkg::ACC_BITS-1:0]  req_code_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [mbp_pkg::ACC_BITS-1:0]       rsp_out_word,
   output logic [mbp_pkg::COUNT_W-1:0]        rsp_byte_count,
   output logic                               rsp_from_flush
);

   logic                         item_valid;
   mbp_pkg::item_type            item;
   mbp_pkg::step_type            step;
   logic                         out_free;
   logic                         advance;

   logic [mbp_pkg::ACC_BITS-1:0] acc_ff, acc_in;
   logic [mbp_pkg::LEN_W-1:0]    free_ff, free_in;
   logic                         out_valid_ff, out_valid_in;
   mbp_pkg::result_type          out_ff, out_in;

   mbp_in_stage u_in_stage (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_bit_length (req_bit_length),
      .req_code_value (req_code_value),
      .advance        (advance),
      .item_valid     (item_valid),
      .item           (item)
   );

   mbp_pack_step u_pack_step (
      .item      (item),
      .acc       (acc_ff),
      .free_bits (free_ff),
      .step      (step)
   );

   assign out_free = !out_valid_ff || rsp_ready;
   assign advance  = item_valid && (out_free || !step.emit);

   always_comb begin
      acc_in       = acc_ff;
      free_in      = free_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (advance) begin
         acc_in  = step.acc_next;
         free_in = step.free_next;
         if (step.emit) begin
            out_valid_in = 1'b1;
            out_in       = step.result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         free_ff      <= mbp_pkg::FREE_FULL;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         free_ff      <= free_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_word   = out_ff.out_word;
   assign rsp_byte_count = out_ff.byte_count;
   assign rsp_from_flush = out_ff.from_flush;

`include "msb_first_bit_packer_core_assert.svh"

   `MBP_ASSERT(a_free_legal, clock, reset,
      (free_ff != '0) && (free_ff <= mbp_pkg::FREE_FULL),
      "free bit count out of range")
   `MBP_ASSERT(a_put_full_word, clock, reset,
      (rsp_valid && !rsp_from_flush) |->
         (rsp_byte_count == mbp_pkg::COUNT_W'(mbp_pkg::ACC_BITS / mbp_pkg::BYTE_BITS)),
      "put result is not a full word")
   `MBP_ASSERT(a_flush_bytes, clock, reset,
      (rsp_valid && rsp_from_flush) |-> ((rsp_byte_count != '0) &&
         (rsp_byte_count <= mbp_pkg::COUNT_W'(mbp_pkg::ACC_BITS / mbp_pkg::BYTE_BITS))),
      "flush byte count out of range")
   `MBP_ASSERT(a_flush_clears, clock, reset,
      (advance && (item.opcode == mbp_pkg::OP_FLUSH)) |=>
         ((free_ff == mbp_pkg::FREE_FULL) && (acc_ff == '0)),
      "flush left the accumulator busy")
   `MBP_ASSERT_ALWAYS(a_reset_state, clock,
      reset |=> ((free_ff == mbp_pkg::FREE_FULL) && !rsp_valid && req_ready),
      "state not cleared by reset")

endmodule

`default_nettype wire
